[hdl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants for the escape-time pixel classifier.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int FRACTION_BITS_DEF = 28;
  localparam int WORD_BITS_DEF     = 32;

  localparam int BOUND_COUNT = 12;
  localparam int BOUND_IDX_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_W        = 32;
  localparam int ITER_W      = 16;
  localparam int SHADE_W     = 7;
  localparam int ATTR_W      = 3;
  localparam int COLOR_W     = 8;
  localparam int LIMIT_W     = 31;

  // sqrt(3) with 30 fraction bits, truncated
  localparam longint SQRT3_Q30 = 64'd1859775393;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTR_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT   = 3'd6;

  // reset values
  localparam logic [IN_W-1:0]    COEF_A_RST      = 32'd268435456;
  localparam logic [ATTR_W-1:0]  ATTR_COUNT_RST  = 3'd3;
  localparam logic [SHADE_W-1:0] SHADE_COUNT_RST = 7'd85;
  localparam logic [ITER_W-1:0]  MAX_ITER_RST    = 16'd150;
  localparam logic [LIMIT_W-1:0] ESC_LIMIT_RST   = 31'd1879048192;

  localparam logic              CMD_BOUND = 1'b0;
  localparam logic              CMD_EVAL  = 1'b1;

endpackage

[hdl/pfc_pixel_if.sv]
// ----------------------------------------------------------------------------
// pfc_pixel_if
// Input channel: bound writes and pixel evaluations.
// ----------------------------------------------------------------------------
interface pfc_pixel_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [pfc_pkg::IN_W-1:0]     point_re;
  logic signed [pfc_pkg::IN_W-1:0]     point_im;
  logic [pfc_pkg::BOUND_IDX_W-1:0]     bound_index;
  logic signed [pfc_pkg::IN_W-1:0]     bound_value;

  modport source(output valid, cmd, point_re, point_im, bound_index, bound_value,
                 input ready);
  modport sink(input valid, cmd, point_re, point_im, bound_index, bound_value,
               output ready);
endinterface

[hdl/pfc_result_if.sv]
// ----------------------------------------------------------------------------
// pfc_result_if
// Output channel: one classification result per evaluated pixel.
// ----------------------------------------------------------------------------
interface pfc_result_if;
  logic                           valid;
  logic                           ready;
  logic [pfc_pkg::COLOR_W-1:0]    pixel_color;
  logic [pfc_pkg::ATTR_W-1:0]     attractor_id;
  logic [pfc_pkg::ITER_W-1:0]     iterations;

  modport source(output valid, pixel_color, attractor_id, iterations, input ready);
  modport sink(input valid, pixel_color, attractor_id, iterations, output ready);
endinterface

[hdl/pfc_cfg_if.sv]
// ----------------------------------------------------------------------------
// pfc_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface pfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::CFG_IDX_W-1:0]   index;
  logic [pfc_pkg::IN_W-1:0]        data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/pfc_mul.sv]
// ----------------------------------------------------------------------------
// pfc_mul
// Shared fixed-point multiplier: floor(a*b / 2^F), registered, with range flag.
// ----------------------------------------------------------------------------
module pfc_mul #(
  parameter int OP_W = 33,
  parameter int WORD_BITS = 32,
  parameter int FRACTION_BITS = 28
) (
  input  logic                        clk,
  input  logic signed [OP_W-1:0]      op_a,
  input  logic signed [OP_W-1:0]      op_b,
  output logic signed [WORD_BITS-1:0] res,
  output logic                        ok
);
  localparam int PW = 2 * OP_W;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] q;
  logic [PW-WORD_BITS:0] hi;

  assign prod = op_a * op_b;
  assign q    = prod >>> FRACTION_BITS;
  assign hi   = q[PW-1:WORD_BITS-1];

  always_ff @(posedge clk) begin
    res <= q[WORD_BITS-1:0];
    ok  <= (&hi) | ~(|hi);
  end
endmodule

[hdl/pfc_div.sv]
// ----------------------------------------------------------------------------
// pfc_div
// Restoring divider, one quotient bit per cycle, for the scaled colour.
// ----------------------------------------------------------------------------
module pfc_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;

  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

[hdl/frothy_basin_pixel_classifier_top.sv]
// ----------------------------------------------------------------------------
// frothy_basin_pixel_classifier_top
// Escape-time attractor classifier, integer mode, one shared multiplier.
//
// Channels: pixel (sink) carries bound writes (cmd 0) and pixel evaluations
// (cmd 1); result (source) returns one transaction per evaluation; cfg (sink)
// writes the seven control registers and is always ready; the user must write
// them only while idle, the block itself does not enforce it. A bound write
// returns nothing. An evaluation runs its products through the shared
// multiplier one after another. A pixel ends when a segment test captures it or
// on an escape or cap stop (with double step, also when the middle point
// escapes); a captured pixel in the scaled colour mode adds a divider run.
// The multiplier sequence and, in the scaled colour mode, the divider set the
// throughput; one pixel is in flight.
// The result sits in an output register until taken; a new transaction is
// accepted while it waits, but the next result waits for the slot to clear.
// Reset restores register defaults; segment bounds must be written before
// pixels that reach the segment tests are evaluated.
// ----------------------------------------------------------------------------
module frothy_basin_pixel_classifier_top #(
  parameter int FRACTION_BITS = pfc_pkg::FRACTION_BITS_DEF,
  parameter int WORD_BITS     = pfc_pkg::WORD_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  pfc_pixel_if.sink    pixel,
  pfc_cfg_if.sink      cfg,
  pfc_result_if.source result
);
  import pfc_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int OW   = (W > 33) ? W : 33;
  localparam int CW   = ((W > LIMIT_W) ? W : LIMIT_W) + 3;
  localparam longint CLOSE_Q = (64'd1 << FRACTION_BITS) / 64'd1000000;
  localparam longint SLOPE   = SQRT3_Q30 >>> (30 - FRACTION_BITS);
  localparam int NUM_W = SHADE_W + ITER_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SX   = 4'd1;
  localparam logic [3:0] ST_SY   = 4'd2;
  localparam logic [3:0] ST_P1   = 4'd3;
  localparam logic [3:0] ST_P2   = 4'd4;
  localparam logic [3:0] ST_P3   = 4'd5;
  localparam logic [3:0] ST_CHK  = 4'd6;
  localparam logic [3:0] ST_M1   = 4'd7;
  localparam logic [3:0] ST_M2   = 4'd8;
  localparam logic [3:0] ST_CLS  = 4'd9;
  localparam logic [3:0] ST_DIV  = 4'd10;
  localparam logic [3:0] ST_COL  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  // control registers
  logic [IN_W-1:0]    coef_a;
  logic               double_step;
  logic               alt_color;
  logic [ATTR_W-1:0]  attractor_count;
  logic [SHADE_W-1:0] shade_count;
  logic [ITER_W-1:0]  max_iter;
  logic [LIMIT_W-1:0] escape_limit;

  logic signed [W-1:0] bounds [BOUND_COUNT];

  logic [3:0]          state;
  logic signed [W-1:0] x, y, sx, sy, p1, p2, m1;
  logic                okacc, m1ok, half;
  logic [ITER_W-1:0]   count;
  logic [ATTR_W-1:0]   id;

  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [W-1:0]  mul_res;
  logic                 mul_ok;

  logic                 div_start, div_busy;
  logic [NUM_W-1:0]     div_quo;

  logic signed [W-1:0]  a_w;
  logic signed [W:0]    halfa;

  assign a_w   = W'($signed(coef_a));
  assign halfa = ($signed({a_w[W-1], a_w}) + $signed({{W{1'b0}}, a_w[W-1]})) >>> 1;

  assign cfg.ready   = 1'b1;
  assign pixel.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a          <= COEF_A_RST;
      double_step     <= 1'b0;
      alt_color       <= 1'b0;
      attractor_count <= ATTR_COUNT_RST;
      shade_count     <= SHADE_COUNT_RST;
      max_iter        <= MAX_ITER_RST;
      escape_limit    <= ESC_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_COEF_A:      coef_a          <= cfg.data;
        REG_DOUBLE_STEP: double_step     <= cfg.data[0];
        REG_ALT_COLOR:   alt_color       <= cfg.data[0];
        REG_ATTR_COUNT:  attractor_count <= cfg.data[ATTR_W-1:0];
        REG_SHADE_COUNT: shade_count     <= cfg.data[SHADE_W-1:0];
        REG_MAX_ITER:    max_iter        <= cfg.data[ITER_W-1:0];
        REG_ESC_LIMIT:   escape_limit    <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready && pixel.cmd == CMD_BOUND &&
        pixel.bound_index < BOUND_IDX_W'(BOUND_COUNT))
      bounds[pixel.bound_index] <= W'($signed(pixel.bound_value));
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SX: begin mul_a = OW'(x);   mul_b = OW'(x); end
      ST_SY: begin mul_a = OW'(y);   mul_b = OW'(y); end
      ST_P1: begin mul_a = OW'(a_w); mul_b = OW'(y); end
      ST_P2: begin mul_a = OW'(x);   mul_b = OW'(y); end
      ST_P3: begin mul_a = OW'(a_w); mul_b = OW'(x); end
      ST_M1: begin mul_a = OW'(SLOPE);  mul_b = OW'(x); end
      ST_M2: begin mul_a = OW'(-SLOPE); mul_b = OW'(x); end
      default: ;
    endcase
  end

  pfc_mul #(.OP_W(OW), .WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk(clk), .op_a(mul_a), .op_b(mul_b), .res(mul_res), .ok(mul_ok)
  );

  // map update and escape test, p3 straight from the multiplier
  logic signed [CW-1:0] mag, lim, d, nx, ny, wmax, wmin;
  logic                 fail;
  always_comb begin
    wmax = (CW'(1) <<< (W - 1)) - CW'(1);
    wmin = -wmax - CW'(1);
    mag  = CW'(sx) + CW'(sy);
    lim  = CW'({1'b0, escape_limit});
    d    = CW'(p2) <<< 1;
    nx   = CW'(sx) - CW'(sy) - CW'(x) - CW'(p1);
    ny   = CW'(y) + d - CW'(mul_res);
    fail = !okacc || !mul_ok || mag > wmax || mag >= lim ||
           (!half && count >= max_iter) ||
           d > wmax || d < wmin || nx > wmax || nx < wmin || ny > wmax || ny < wmin;
  end

  // segment tests
  logic signed [W+2:0] dt, dr, dl, cq;
  logic top_hit, right_hit, left_hit, two, three;
  logic [ATTR_W-1:0] cls_id;
  always_comb begin
    cq    = (W+3)'(CLOSE_Q);
    dt    = (W+3)'(halfa) - (W+3)'(y);
    dr    = (W+3)'(m1) - (W+3)'(a_w) - (W+3)'(y);
    dl    = (W+3)'(mul_res) - (W+3)'(a_w) - (W+3)'(y);
    two   = !double_step && attractor_count == ATTR_W'(2);
    three = double_step && attractor_count == ATTR_W'(3);
    top_hit   = dt < cq && dt > -cq && x >= bounds[0] && x <= bounds[1];
    right_hit = m1ok && dr < cq && dr > -cq && x <= bounds[8] && x >= bounds[9];
    left_hit  = mul_ok && dl < cq && dl > -cq && x <= bounds[4] && x >= bounds[5];
    cls_id = '0;
    if (top_hit) begin
      if (two || three)        cls_id = ATTR_W'(1);
      else if (x <= bounds[2]) cls_id = ATTR_W'(1);
      else if (x >= bounds[3]) cls_id = double_step ? ATTR_W'(2) : ATTR_W'(1);
    end else if (right_hit) begin
      if (two)                  cls_id = ATTR_W'(2);
      else if (three)           cls_id = ATTR_W'(3);
      else if (x >= bounds[10]) cls_id = double_step ? ATTR_W'(4) : ATTR_W'(2);
      else if (x <= bounds[11]) cls_id = double_step ? ATTR_W'(6) : ATTR_W'(3);
    end else if (left_hit) begin
      if (two || three)        cls_id = ATTR_W'(2);
      else if (x >= bounds[6]) cls_id = double_step ? ATTR_W'(5) : ATTR_W'(3);
      else if (x <= bounds[7]) cls_id = double_step ? ATTR_W'(3) : ATTR_W'(2);
    end
  end

  assign div_start = (state == ST_CLS) && cls_id != '0 && alt_color;

  pfc_div #(.NUM_W(NUM_W), .DEN_W(ITER_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUM_W'(shade_count) * NUM_W'(count)), .den(max_iter),
    .busy(div_busy), .quo(div_quo)
  );

  // colour mapping
  logic [SHADE_W-1:0] base, c1;
  logic [10:0]        csum;
  logic [COLOR_W-1:0] color;
  always_comb begin
    if (alt_color) base = div_quo[SHADE_W-1:0];
    else           base = (count > ITER_W'(shade_count)) ? shade_count : count[SHADE_W-1:0];
    c1    = (base == '0) ? SHADE_W'(1) : base;
    csum  = 11'(c1) + 11'(shade_count) * 11'(id - ATTR_W'(1));
    color = (csum > 11'd255) ? 8'hFF : csum[COLOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
    end else begin
      // ST_OUT drives valid itself
      if (result.valid && result.ready && state != ST_OUT) result.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pixel.valid && pixel.cmd == CMD_EVAL) begin
            x     <= W'($signed(pixel.point_re));
            y     <= W'($signed(pixel.point_im));
            count <= '0;
            id    <= '0;
            half  <= 1'b0;
            state <= ST_SX;
          end
        end
        ST_SX: state <= ST_SY;
        ST_SY: begin sx <= mul_res; okacc <= mul_ok; state <= ST_P1; end
        ST_P1: begin sy <= mul_res; okacc <= okacc & mul_ok; state <= ST_P2; end
        ST_P2: begin p1 <= mul_res; okacc <= okacc & mul_ok; state <= ST_P3; end
        ST_P3: begin p2 <= mul_res; okacc <= okacc & mul_ok; state <= ST_CHK; end
        ST_CHK: begin
          if (fail) begin
            state <= ST_OUT;
          end else begin
            x <= nx[W-1:0];
            y <= ny[W-1:0];
            if (double_step && !half) begin
              half  <= 1'b1;
              state <= ST_SX;
            end else begin
              half  <= 1'b0;
              count <= count + 1'b1;
              state <= ST_M1;
            end
          end
        end
        ST_M1: state <= ST_M2;
        ST_M2: begin m1 <= mul_res; m1ok <= mul_ok; state <= ST_CLS; end
        ST_CLS: begin
          id <= cls_id;
          if (cls_id == '0)   state <= ST_SX;
          else if (alt_color) state <= ST_DIV;
          else                state <= ST_COL;
        end
        ST_DIV: if (!div_busy) state <= ST_COL;
        ST_COL: state <= ST_OUT;
        ST_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.attractor_id <= id;
            result.iterations   <= count;
            result.pixel_color  <= (id == '0) ? '0 : color;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
